>>> rtl/dhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhs_pkg: shared types and constants of the depth hole search block
// Field widths, register map, queue entry and configuration bundle.
// ----------------------------------------------------------------------------
package dhs_pkg;

  // Fixed field widths of the stream items
  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int DEPTH_W = 16;
  localparam int CFG_W   = 16;
  localparam int COORD_W = 32;

  // Stream bus widths (fields packed from bit 0, padded to whole bytes)
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 104;

  // Register bus
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_FOCAL_X  = 2'd0;
  localparam logic [1:0] REG_FOCAL_Y  = 2'd1;
  localparam logic [1:0] REG_CENTRE_X = 2'd2;
  localparam logic [1:0] REG_CENTRE_Y = 2'd3;

  // Register reset values, 4 fractional bits
  localparam logic [CFG_W-1:0] FOCAL_X_RST  = 16'd9600;
  localparam logic [CFG_W-1:0] FOCAL_Y_RST  = 16'd9600;
  localparam logic [CFG_W-1:0] CENTRE_X_RST = 16'd5120;
  localparam logic [CFG_W-1:0] CENTRE_Y_RST = 16'd3840;

  // Default geometry
  localparam int FRAME_WIDTH_DEF  = 640;
  localparam int FRAME_HEIGHT_DEF = 480;
  localparam int SEARCH_RADII_DEF = 10;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // Item kind after classification
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } dhs_kind_e;

  // Queue entry between front and back
  typedef struct packed {
    dhs_kind_e           kind;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [DEPTH_W-1:0]  depth;
  } dhs_item_t;

  // Camera intrinsics
  typedef struct packed {
    logic [CFG_W-1:0] focal_x;
    logic [CFG_W-1:0] focal_y;
    logic [CFG_W-1:0] centre_x;
    logic [CFG_W-1:0] centre_y;
  } dhs_cfg_t;

endpackage

>>> rtl/dhs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhs_queue: short item queue between front and back
// Register-based FIFO; the head entry is visible while valid is high.
// ----------------------------------------------------------------------------
module dhs_queue #(
  parameter int DEPTH = dhs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  dhs_pkg::dhs_item_t push_item_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output dhs_pkg::dhs_item_t pop_item_o
);
  import dhs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dhs_item_t       slot_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    count_d = count_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

endmodule

>>> rtl/dhs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhs_front: input side of the depth hole search
// Accepts stream transactions, classifies them and drops writes off the frame.
// ----------------------------------------------------------------------------
module dhs_front #(
  parameter int FRAME_WIDTH  = dhs_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = dhs_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [9:0] pixel_col, [18:10] pixel_row, [34:19] depth_value, [39:35] zero
  input  logic [dhs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] func
  input  logic                            s_axis_tuser,
  input  logic                            clearing_i,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output dhs_pkg::dhs_item_t              push_item_o
);
  import dhs_pkg::*;

  logic                accept;
  logic                in_frame;
  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;
  logic [DEPTH_W-1:0]  depth;
  dhs_kind_e           kind;

  // Unpack the transaction
  assign col   = s_axis_tdata[COL_W-1:0];
  assign row   = s_axis_tdata[COL_W+ROW_W-1:COL_W];
  assign depth = s_axis_tdata[COL_W+ROW_W+DEPTH_W-1:COL_W+ROW_W];
  assign kind  = s_axis_tuser ? KIND_QUERY : KIND_WRITE;

  // Classify: writes outside the frame are taken and dropped
  assign in_frame = (32'(col) < 32'(FRAME_WIDTH)) && (32'(row) < 32'(FRAME_HEIGHT));

  // Hold off input while the frame store is cleared
  assign s_axis_tready = push_ready_i && !clearing_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign push_valid_o      = accept && ((kind == KIND_QUERY) || in_frame);
  assign push_item_o.kind  = kind;
  assign push_item_o.col   = col;
  assign push_item_o.row   = row;
  assign push_item_o.depth = depth;

  a_no_push_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_i |-> !push_valid_o)
    else $error("item pushed during frame clear");

endmodule

>>> rtl/dhs_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhs_search: frame store and window search
// Writes depth samples, clears the store after reset and scans growing
// windows around a queried pixel for the first nonzero sample.
// ----------------------------------------------------------------------------
module dhs_search #(
  parameter int FRAME_WIDTH  = dhs_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = dhs_pkg::FRAME_HEIGHT_DEF,
  parameter int SEARCH_RADII = dhs_pkg::SEARCH_RADII_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              item_valid_i,
  output logic                              item_ready_o,
  input  dhs_pkg::dhs_item_t                item_i,
  output logic                              clearing_o,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output logic                              res_found_o,
  output logic [dhs_pkg::DEPTH_W-1:0]       res_z_o,
  output logic [$clog2(FRAME_WIDTH)-1:0]    res_hc_o,
  output logic [$clog2(FRAME_HEIGHT)-1:0]   res_hr_o,
  output logic [dhs_pkg::COL_W-1:0]         res_qcol_o,
  output logic [dhs_pkg::ROW_W-1:0]         res_qrow_o
);
  import dhs_pkg::*;

  localparam int FRAME_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW     = $clog2(FRAME_DEPTH);
  localparam int HC_W   = $clog2(FRAME_WIDTH);
  localparam int HR_W   = $clog2(FRAME_HEIGHT);
  localparam int RAD_W  = $clog2(SEARCH_RADII);
  localparam int OW     = $clog2(2 * SEARCH_RADII);
  localparam int JSPAN  = ((2 ** COL_W) > FRAME_WIDTH) ? (2 ** COL_W) : FRAME_WIDTH;
  localparam int KSPAN  = ((2 ** ROW_W) > FRAME_HEIGHT) ? (2 ** ROW_W) : FRAME_HEIGHT;
  localparam int JW     = $clog2(JSPAN + SEARCH_RADII) + 1;
  localparam int KW     = $clog2(KSPAN + SEARCH_RADII) + 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_WAIT  = 5'b01000,
    S_HAND  = 5'b10000
  } search_state_e;

  search_state_e        state_q, state_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [RAD_W-1:0]     r_q, r_d;
  logic [OW-1:0]        dj_q, dj_d;
  logic [OW-1:0]        dk_q, dk_d;
  logic                 p_valid_q, p_valid_d;
  logic                 p_in_q, p_in_d;
  logic signed [JW-1:0] p_j_q, p_j_d;
  logic signed [KW-1:0] p_k_q, p_k_d;
  logic                 found_q, found_d;
  logic [DEPTH_W-1:0]   z_q, z_d;
  logic [HC_W-1:0]      hc_q, hc_d;
  logic [HR_W-1:0]      hr_q, hr_d;

  logic [DEPTH_W-1:0]   mem_q [FRAME_DEPTH];
  logic [DEPTH_W-1:0]   rd_q;
  logic                 wr_en, rd_en;
  logic [DEPTH_W-1:0]   wr_data;
  logic [AW-1:0]        mem_addr, calc_addr;
  logic [HC_W-1:0]      col_sel;
  logic [HR_W-1:0]      row_sel;

  logic signed [JW-1:0] j;
  logic signed [KW-1:0] k;
  logic                 in_frame;
  logic [OW-1:0]        span_last;
  logic                 last_dk, last_dj, last_r;
  logic                 hit_now;

  // Current scan position within the window
  assign j = $signed(JW'(col_q)) - $signed(JW'(r_q)) + $signed(JW'(dj_q));
  assign k = $signed(KW'(row_q)) - $signed(KW'(r_q)) + $signed(KW'(dk_q));
  assign in_frame = !j[JW-1] && (j[JW-2:0] < (JW-1)'(FRAME_WIDTH)) &&
                    !k[KW-1] && (k[KW-2:0] < (KW-1)'(FRAME_HEIGHT));
  assign span_last = OW'({r_q, 1'b0}) - OW'(1);
  assign last_dk   = (dk_q == span_last);
  assign last_dj   = (dj_q == span_last);
  assign last_r    = (r_q == RAD_W'(SEARCH_RADII - 1));

  // Sample read last cycle is a hit
  assign hit_now = p_valid_q && p_in_q && (rd_q != '0);

  // Frame address: row-major, from the queue head or the scan position
  assign col_sel   = (state_q == S_SCAN) ? j[HC_W-1:0] : HC_W'(item_i.col);
  assign row_sel   = (state_q == S_SCAN) ? k[HR_W-1:0] : HR_W'(item_i.row);
  assign calc_addr = AW'(row_sel) * AW'(FRAME_WIDTH) + AW'(col_sel);
  assign mem_addr  = (state_q == S_CLEAR) ? clr_q : calc_addr;

  // Sequence clear, writes and window scans
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    col_d        = col_q;
    row_d        = row_q;
    r_d          = r_q;
    dj_d         = dj_q;
    dk_d         = dk_q;
    p_valid_d    = 1'b0;
    p_in_d       = p_in_q;
    p_j_d        = p_j_q;
    p_k_d        = p_k_q;
    found_d      = found_q;
    z_d          = z_q;
    hc_d         = hc_q;
    hr_d         = hr_q;
    wr_en        = 1'b0;
    wr_data      = item_i.depth;
    rd_en        = 1'b0;
    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(FRAME_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          if (item_i.kind == KIND_WRITE) begin
            wr_en = 1'b1;
          end else begin
            col_d   = item_i.col;
            row_d   = item_i.row;
            r_d     = RAD_W'(1);
            dj_d    = '0;
            dk_d    = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit_now) begin
          found_d = 1'b1;
          z_d     = rd_q;
          hc_d    = p_j_q[HC_W-1:0];
          hr_d    = p_k_q[HR_W-1:0];
          state_d = S_HAND;
        end else begin
          rd_en     = in_frame;
          p_valid_d = 1'b1;
          p_in_d    = in_frame;
          p_j_d     = j;
          p_k_d     = k;
          if (last_dk) begin
            dk_d = '0;
            if (last_dj) begin
              dj_d = '0;
              if (last_r) begin
                state_d = S_WAIT;
              end else begin
                r_d = r_q + RAD_W'(1);
              end
            end else begin
              dj_d = dj_q + OW'(1);
            end
          end else begin
            dk_d = dk_q + OW'(1);
          end
        end
      end
      S_WAIT: begin
        found_d = hit_now;
        z_d     = hit_now ? rd_q : '0;
        hc_d    = p_j_q[HC_W-1:0];
        hr_d    = p_k_q[HR_W-1:0];
        state_d = S_HAND;
      end
      S_HAND: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      r_q       <= '0;
      dj_q      <= '0;
      dk_q      <= '0;
      p_valid_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      r_q       <= r_d;
      dj_q      <= dj_d;
      dk_q      <= dk_d;
      p_valid_q <= p_valid_d;
      found_q   <= found_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    row_q  <= row_d;
    p_in_q <= p_in_d;
    p_j_q  <= p_j_d;
    p_k_q  <= p_k_d;
    z_q    <= z_d;
    hc_q   <= hc_d;
    hr_q   <= hr_d;
  end

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[mem_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[mem_addr];
    end
  end

  assign clearing_o = (state_q == S_CLEAR);
  assign res_found_o = found_q;
  assign res_z_o     = z_q;
  assign res_hc_o    = hc_q;
  assign res_hr_o    = hr_q;
  assign res_qcol_o  = col_q;
  assign res_qrow_o  = row_q;

  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_found_o |-> res_z_o != '0)
    else $error("hit reported with zero depth");

  a_read_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> $past(state_q == S_SCAN))
    else $error("window read outside a scan");

endmodule

>>> rtl/dhs_deproj.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhs_deproj: pinhole deprojection of a search hit
// Forms (16*pix - centre) * z * 16 and divides by the focal length with a
// shared one-bit-per-cycle divider, x first, then y; saturates to 32 bits.
// ----------------------------------------------------------------------------
module dhs_deproj #(
  parameter int FRAME_WIDTH  = dhs_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = dhs_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dhs_pkg::dhs_cfg_t                 cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              in_found_i,
  input  logic [dhs_pkg::DEPTH_W-1:0]       in_z_i,
  input  logic [$clog2(FRAME_WIDTH)-1:0]    in_hc_i,
  input  logic [$clog2(FRAME_HEIGHT)-1:0]   in_hr_i,
  input  logic [dhs_pkg::COL_W-1:0]         in_qcol_i,
  input  logic [dhs_pkg::ROW_W-1:0]         in_qrow_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_found_o,
  output logic [dhs_pkg::COORD_W-1:0]       out_x_o,
  output logic [dhs_pkg::COORD_W-1:0]       out_y_o,
  output logic [dhs_pkg::DEPTH_W-1:0]       out_z_o,
  output logic [dhs_pkg::COL_W-1:0]         out_col_o,
  output logic [dhs_pkg::ROW_W-1:0]         out_row_o
);
  import dhs_pkg::*;

  localparam int HC_W   = $clog2(FRAME_WIDTH);
  localparam int HR_W   = $clog2(FRAME_HEIGHT);
  localparam int PW     = (HC_W > HR_W) ? HC_W : HR_W;
  localparam int MAG_W  = (PW + 4 > CFG_W) ? PW + 4 : CFG_W;
  localparam int PROD_W = MAG_W + DEPTH_W;
  localparam int DIV_W  = PROD_W + 4;
  localparam int CNT_W  = $clog2(DIV_W);

  typedef enum logic [4:0] {
    D_IDLE = 5'b00001,
    D_MUL  = 5'b00010,
    D_DIV  = 5'b00100,
    D_SAT  = 5'b01000,
    D_DONE = 5'b10000
  } deproj_state_e;

  deproj_state_e        state_q, state_d;
  logic                 axis_q, axis_d;
  logic                 found_q, found_d;
  logic [DEPTH_W-1:0]   z_q, z_d;
  logic [HC_W-1:0]      hc_q, hc_d;
  logic [HR_W-1:0]      hr_q, hr_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [COORD_W-1:0]   x_q, x_d;
  logic [COORD_W-1:0]   y_q, y_d;
  logic                 neg_q, neg_d;
  logic [CFG_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_found_q;
  logic [COORD_W-1:0]   out_x_q, out_y_q;
  logic [DEPTH_W-1:0]   out_z_q;
  logic [COL_W-1:0]     out_col_q;
  logic [ROW_W-1:0]     out_row_q;
  logic                 out_load;

  logic [PW-1:0]        pix;
  logic [CFG_W-1:0]     focal, centre;
  logic [MAG_W-1:0]     pix16, cext, mag;
  logic                 below;
  logic [CFG_W:0]       trial;
  logic                 fits;
  logic [COORD_W-1:0]   sat_val;

  // Operands of the current axis
  assign pix    = axis_q ? PW'(hr_q) : PW'(hc_q);
  assign focal  = axis_q ? cfg_i.focal_y : cfg_i.focal_x;
  assign centre = axis_q ? cfg_i.centre_y : cfg_i.centre_x;
  assign pix16  = MAG_W'({pix, 4'b0000});
  assign cext   = MAG_W'(centre);
  assign below  = (pix16 < cext);
  assign mag    = below ? (cext - pix16) : (pix16 - cext);

  // Restoring division step
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = (trial >= {1'b0, focal});

  // Truncated quotient with sign, clamped to 32 bits
  always_comb begin
    if (focal == '0) begin
      sat_val = '0;
    end else if (neg_q) begin
      sat_val = (quo_q > DIV_W'(64'h8000_0000)) ? 32'h8000_0000
                                                : (32'd0 - quo_q[COORD_W-1:0]);
    end else begin
      sat_val = (quo_q > DIV_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo_q[COORD_W-1:0];
    end
  end

  assign out_load = (state_q == D_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d    = state_q;
    axis_d     = axis_q;
    found_d    = found_q;
    z_d        = z_q;
    hc_d       = hc_q;
    hr_d       = hr_q;
    col_d      = col_q;
    row_d      = row_q;
    x_d        = x_q;
    y_d        = y_q;
    neg_d      = neg_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    case (state_q)
      D_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          found_d = in_found_i;
          z_d     = in_found_i ? in_z_i : '0;
          hc_d    = in_hc_i;
          hr_d    = in_hr_i;
          col_d   = in_found_i ? COL_W'(in_hc_i) : in_qcol_i;
          row_d   = in_found_i ? ROW_W'(in_hr_i) : in_qrow_i;
          x_d     = '0;
          y_d     = '0;
          axis_d  = 1'b0;
          state_d = in_found_i ? D_MUL : D_DONE;
        end
      end
      D_MUL: begin
        // Product is registered as the dividend
        neg_d   = below;
        quo_d   = {PROD_W'(mag) * PROD_W'(z_q), 4'b0000};
        rem_d   = '0;
        cnt_d   = '0;
        state_d = D_DIV;
      end
      D_DIV: begin
        rem_d = fits ? CFG_W'(trial - {1'b0, focal}) : CFG_W'(trial);
        quo_d = {quo_q[DIV_W-2:0], fits};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          state_d = D_SAT;
        end
      end
      D_SAT: begin
        if (axis_q) begin
          y_d     = sat_val;
          state_d = D_DONE;
        end else begin
          x_d     = sat_val;
          axis_d  = 1'b1;
          state_d = D_MUL;
        end
      end
      D_DONE: begin
        if (out_load) begin
          state_d = D_IDLE;
        end
      end
      default: begin
        state_d = D_IDLE;
      end
    endcase
  end

  // Output register: hold until taken, reload behind a taken transaction
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= D_IDLE;
      axis_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    z_q     <= z_d;
    hc_q    <= hc_d;
    hr_q    <= hr_d;
    col_q   <= col_d;
    row_q   <= row_d;
    x_q     <= x_d;
    y_q     <= y_d;
    neg_q   <= neg_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    if (out_load) begin
      out_found_q <= found_q;
      out_x_q     <= x_q;
      out_y_q     <= y_q;
      out_z_q     <= z_q;
      out_col_q   <= col_q;
      out_row_q   <= row_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_found_o = out_found_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;

  a_miss_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_found_o |-> out_x_o == '0 && out_y_o == '0 && out_z_o == '0)
    else $error("miss result not cleared");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == D_SAT |-> $past(state_q == D_DIV) && $past(cnt_q) == CNT_W'(DIV_W - 1))
    else $error("division ended early");

endmodule

>>> rtl/depth_hole_search_deproject.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_hole_search_deproject: depth hole search with pinhole deprojection
// Stores a depth frame, finds the nearest valid sample around a queried pixel
// and turns it into a camera-space point in millimetres.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  s_axis    in   tvalid/tready     tuser func; tdata col, row, depth
//  m_axis    out  tvalid/tready     tuser found; tdata x, y, z, hit col, hit row
//  apb       in   psel/penable      focal_x, focal_y, centre_x, centre_y
//
//  A depth write uses the frame store write port; writes stream at one per cycle
//  through the item queue while the search is idle.
//  A query scans up to sum over r=1..SEARCH_RADII-1 of (2r)^2 positions (1140 for
//  ten radii), reading the frame store at one position per cycle, then passes x
//  and y in turn through the shared one-bit-per-cycle divider (DIV_W = 36 by default).
//  After reset the frame store is cleared one entry per cycle, all
//  FRAME_WIDTH*FRAME_HEIGHT entries (307200 by default), with s_axis_tready low.
//  A stalled m_axis holds its result while the next query is searched.
// ----------------------------------------------------------------------------
module depth_hole_search_deproject #(
  parameter int FRAME_WIDTH  = dhs_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = dhs_pkg::FRAME_HEIGHT_DEF,
  parameter int SEARCH_RADII = dhs_pkg::SEARCH_RADII_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [9:0] pixel_col, [18:10] pixel_row, [34:19] depth_value, [39:35] zero
  input  logic [dhs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] func
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] point_x, [63:32] point_y, [79:64] point_z, [89:80] hit_col,
  // [98:90] hit_row, [103:99] zero
  output logic [dhs_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [0] found
  output logic                            m_axis_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dhs_pkg::APB_AW-1:0]      paddr,
  input  logic [dhs_pkg::APB_DW-1:0]      pwdata,
  output logic [dhs_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);
  import dhs_pkg::*;

  localparam int HC_W = $clog2(FRAME_WIDTH);
  localparam int HR_W = $clog2(FRAME_HEIGHT);

  dhs_cfg_t            cfg_q, cfg_d;
  logic [1:0]          reg_idx;
  logic                cfg_wr;

  logic                clearing;
  logic                push_valid, push_ready;
  dhs_item_t           push_item;
  logic                pop_valid, pop_ready;
  dhs_item_t           pop_item;

  logic                res_valid, res_ready, res_found;
  logic [DEPTH_W-1:0]  res_z;
  logic [HC_W-1:0]     res_hc;
  logic [HR_W-1:0]     res_hr;
  logic [COL_W-1:0]    res_qcol;
  logic [ROW_W-1:0]    res_qrow;

  logic [COORD_W-1:0]  point_x, point_y;
  logic [DEPTH_W-1:0]  point_z;
  logic [COL_W-1:0]    hit_col;
  logic [ROW_W-1:0]    hit_row;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_FOCAL_X:  cfg_d.focal_x  = pwdata[CFG_W-1:0];
        REG_FOCAL_Y:  cfg_d.focal_y  = pwdata[CFG_W-1:0];
        REG_CENTRE_X: cfg_d.centre_x = pwdata[CFG_W-1:0];
        REG_CENTRE_Y: cfg_d.centre_y = pwdata[CFG_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FOCAL_X:  prdata = APB_DW'(cfg_q.focal_x);
      REG_FOCAL_Y:  prdata = APB_DW'(cfg_q.focal_y);
      REG_CENTRE_X: prdata = APB_DW'(cfg_q.centre_x);
      REG_CENTRE_Y: prdata = APB_DW'(cfg_q.centre_y);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.focal_x  <= FOCAL_X_RST;
      cfg_q.focal_y  <= FOCAL_Y_RST;
      cfg_q.centre_x <= CENTRE_X_RST;
      cfg_q.centre_y <= CENTRE_Y_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accept and classify
  dhs_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .clearing_i    (clearing),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  dhs_queue #(
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Back: frame store and window search
  dhs_search #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .SEARCH_RADII (SEARCH_RADII)
  ) u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (pop_valid),
    .item_ready_o (pop_ready),
    .item_i       (pop_item),
    .clearing_o   (clearing),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_found_o  (res_found),
    .res_z_o      (res_z),
    .res_hc_o     (res_hc),
    .res_hr_o     (res_hr),
    .res_qcol_o   (res_qcol),
    .res_qrow_o   (res_qrow)
  );

  // Back: deprojection and output register
  dhs_deproj #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_deproj (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .in_found_i  (res_found),
    .in_z_i      (res_z),
    .in_hc_i     (res_hc),
    .in_hr_i     (res_hr),
    .in_qcol_i   (res_qcol),
    .in_qrow_i   (res_qrow),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_found_o (m_axis_tuser),
    .out_x_o     (point_x),
    .out_y_o     (point_y),
    .out_z_o     (point_z),
    .out_col_o   (hit_col),
    .out_row_o   (hit_row)
  );

  // Pack the result transaction
  assign m_axis_tdata = {(M_TDATA_W - 2*COORD_W - DEPTH_W - COL_W - ROW_W)'(0),
                         hit_row, hit_col, point_z, point_y, point_x};

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for depth_hole_search_deproject
// Streams depth writes and pixel queries into the block, keeps a private copy
// of the depth frame and the intrinsics, and checks every returned point field
// by field against an in-bench search and deprojection or a directed expectation, in arrival order.
// ----------------------------------------------------------------------------
module tb;
  import dhs_pkg::*;

  localparam int FRAME_W      = FRAME_WIDTH_DEF;
  localparam int FRAME_H      = FRAME_HEIGHT_DEF;
  localparam int RADII        = SEARCH_RADII_DEF;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 175;
  localparam int DRAIN_CYCLES = 200;

  // One returned point, as it travels on m_axis
  typedef struct {
    logic               found;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [DEPTH_W-1:0] pz;
    logic [COL_W-1:0]   hc;
    logic [ROW_W-1:0]   hr;
  } point_t;

  // One directed stimulus row; typed rows carry their expected point
  typedef struct {
    dhs_kind_e          kind;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [DEPTH_W-1:0] dval;
    bit                 typed;
    logic               found;
    logic [DEPTH_W-1:0] z;
  } probe_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // [9:0] pixel_col, [18:10] pixel_row, [34:19] depth_value, [39:35] zero
  logic [S_TDATA_W-1:0] s_axis_tdata;
  // [0] func
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [31:0] point_x, [63:32] point_y, [79:64] point_z, [89:80] hit_col,
  // [98:90] hit_row, [103:99] zero
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // [0] found
  logic                 m_axis_tuser;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  // Bench copy of the frame store and the intrinsics
  bit [DEPTH_W-1:0] frame_mm [FRAME_W*FRAME_H];
  dhs_cfg_t         cfg;
  point_t           points_due[$];
  probe_t           directed_rows[$];
  int unsigned      mismatches;
  bit               calm;

  depth_hole_search_deproject #(
    .FRAME_WIDTH  (FRAME_W),
    .FRAME_HEIGHT (FRAME_H),
    .SEARCH_RADII (RADII)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 100 MHz clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Hard stop: clearing pass plus every item at its slowest, taken several times
  initial begin
    #80000000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch on %0s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // Pinhole deprojection of one axis, Q4 millimetres, truncated and saturated
  function automatic logic [COORD_W-1:0] to_mm(input int pix,
                                               input logic [CFG_W-1:0] centre, focal,
                                               input logic [DEPTH_W-1:0] z);
    longint num, q;
    if (focal == '0) return '0;
    num = (longint'(pix) * 16 - longint'(centre)) * longint'(z) * 16;
    q = num / longint'(focal);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return 32'(q);
  endfunction

  // Grow the square window until a nonzero sample turns up, then deproject it
  function automatic point_t search_point(input logic [COL_W-1:0] qc,
                                          input logic [ROW_W-1:0] qr);
    point_t p;
    int c, v;
    c = int'(qc);
    v = int'(qr);
    p.found = 1'b0;
    p.px = '0;
    p.py = '0;
    p.pz = '0;
    p.hc = qc;
    p.hr = qr;
    for (int r = 0; r < RADII && !p.found; r++) begin
      for (int j = c - r; j < c + r && !p.found; j++) begin
        for (int k = v - r; k < v + r && !p.found; k++) begin
          if (j >= 0 && k >= 0 && j < FRAME_W && k < FRAME_H &&
              frame_mm[k*FRAME_W + j] != '0) begin
            p.found = 1'b1;
            p.pz = frame_mm[k*FRAME_W + j];
            p.hc = COL_W'(j);
            p.hr = ROW_W'(k);
          end
        end
      end
    end
    if (p.found) begin
      p.px = to_mm(int'(p.hc), cfg.centre_x, cfg.focal_x, p.pz);
      p.py = to_mm(int'(p.hr), cfg.centre_y, cfg.focal_y, p.pz);
    end
    return p;
  endfunction

  function automatic int idle_gap();
    if (calm) return 0;
    return ($urandom_range(99) < 10) ? int'($urandom_range(4, 1)) : 0;
  endfunction

  // Pick positions biased toward the frame borders and beyond
  function automatic int pick_col();
    case ($urandom_range(7))
      0: return int'($urandom_range(9));
      1: return int'($urandom_range(649, 630));
      2: return int'($urandom_range(1023));
      default: return int'($urandom_range(FRAME_W - 1));
    endcase
  endfunction

  function automatic int pick_row();
    case ($urandom_range(7))
      0: return int'($urandom_range(9));
      1: return int'($urandom_range(489, 470));
      2: return int'($urandom_range(511));
      default: return int'($urandom_range(FRAME_H - 1));
    endcase
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_depth();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return DEPTH_W'($urandom);
    endcase
  endfunction

  // Drive one transaction on s_axis, then record its effect on the model
  task automatic push_item(input dhs_kind_e kind, input logic [COL_W-1:0] col,
                           input logic [ROW_W-1:0] row, input logic [DEPTH_W-1:0] dval,
                           input bit typed, input point_t want);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {5'd0, dval, row, col};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (kind == KIND_WRITE) begin
      if (col < FRAME_W && row < FRAME_H) begin
        frame_mm[int'(row)*FRAME_W + int'(col)] = dval;
      end
    end else begin
      points_due.push_back(typed ? want : search_point(col, row));
    end
    @(negedge clk_i);
  endtask

  // One APB transfer: setup, access, then return to idle
  task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [CFG_W-1:0] val,
                          output logic [APB_DW-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Load all four intrinsics, read them back, and adopt them
  task automatic set_intrinsics(input dhs_cfg_t c);
    logic [1:0]       idx[4]  = '{REG_FOCAL_X, REG_FOCAL_Y, REG_CENTRE_X, REG_CENTRE_Y};
    logic [CFG_W-1:0] vals[4] = '{c.focal_x, c.focal_y, c.centre_x, c.centre_y};
    logic [APB_DW-1:0] rd;
    for (int i = 0; i < 4; i++) apb_xfer(1'b1, idx[i], vals[i], rd);
    for (int i = 0; i < 4; i++) begin
      apb_xfer(1'b0, idx[i], '0, rd);
      if (rd !== {16'd0, vals[i]}) report_mismatch($sformatf("register %0d", i),
                                                  {16'd0, vals[i]}, rd);
    end
    cfg = c;
  endtask

  task automatic add_probe(input dhs_kind_e kind, input logic [COL_W-1:0] col,
                           input logic [ROW_W-1:0] row, input logic [DEPTH_W-1:0] dval,
                           input bit typed, input logic found, input logic [DEPTH_W-1:0] z);
    probe_t p;
    p.kind  = kind;
    p.col   = col;
    p.row   = row;
    p.dval  = dval;
    p.typed = typed;
    p.found = found;
    p.z     = z;
    directed_rows.push_back(p);
  endtask

  // Receiver side: stall at random except during the calm phase
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 20);
  end

  // Compare each returned point against the oldest expectation
  always @(posedge clk_i) begin : result_check
    point_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.found = m_axis_tuser;
      got.px    = m_axis_tdata[31:0];
      got.py    = m_axis_tdata[63:32];
      got.pz    = m_axis_tdata[79:64];
      got.hc    = m_axis_tdata[89:80];
      got.hr    = m_axis_tdata[98:90];
      if (points_due.size() == 0) begin
        report_mismatch("unexpected point", '0, got.px);
      end else begin
        want = points_due.pop_front();
        if (got.found !== want.found) report_mismatch("found", 32'(want.found), 32'(got.found));
        if (got.px !== want.px) report_mismatch("point_x", want.px, got.px);
        if (got.py !== want.py) report_mismatch("point_y", want.py, got.py);
        if (got.pz !== want.pz) report_mismatch("point_z", 32'(want.pz), 32'(got.pz));
        if (got.hc !== want.hc) report_mismatch("hit_col", 32'(want.hc), 32'(got.hc));
        if (got.hr !== want.hr) report_mismatch("hit_row", 32'(want.hr), 32'(got.hr));
      end
    end
  end

  initial begin : stimulus
    dhs_cfg_t plan[PHASES];
    probe_t   p;
    point_t   want;
    int       sent, pick, cc, cr, nw;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    mismatches    = 0;
    calm          = 1'b0;

    // Intrinsics per phase, fields ordered focal_x, focal_y, centre_x, centre_y
    plan[0] = {FOCAL_X_RST, FOCAL_Y_RST, CENTRE_X_RST, CENTRE_Y_RST};
    plan[1] = {16'd1, 16'd1, 16'd0, 16'hFFFF};        // saturate both ways
    plan[2] = {16'd0, 16'hFFFF, 16'hFFFF, 16'd0};     // zero horizontal focal
    plan[3] = {FOCAL_X_RST, FOCAL_Y_RST, CENTRE_X_RST, CENTRE_Y_RST};
    plan[4] = {16'hFFFF, 16'd0, 16'd0, 16'hFFFF};     // zero vertical focal
    plan[5] = {16'd16, 16'd16, CENTRE_X_RST, CENTRE_Y_RST};
    plan[6] = {CFG_W'($urandom_range(65535, 16)), CFG_W'($urandom_range(65535, 16)),
               CFG_W'($urandom), CFG_W'($urandom)};

    // Directed rows: empty frame, borders, off-frame writes and queries,
    // a cleared pixel and hits found at several radii
    add_probe(KIND_QUERY, 10'd0,    9'd0,   16'd0,      1'b1, 1'b0, 16'd0);
    add_probe(KIND_QUERY, 10'd639,  9'd479, 16'd0,      1'b1, 1'b0, 16'd0);
    add_probe(KIND_QUERY, 10'd1023, 9'd511, 16'hFFFF,   1'b1, 1'b0, 16'd0);
    add_probe(KIND_WRITE, 10'd320,  9'd240, 16'd1000,   1'b0, 1'b0, 16'd0);
    add_probe(KIND_QUERY, 10'd320,  9'd240, 16'd0,      1'b1, 1'b1, 16'd1000);
    add_probe(KIND_WRITE, 10'd0,    9'd0,   16'hFFFF,   1'b0, 1'b0, 16'd0);
    add_probe(KIND_QUERY, 10'd0,    9'd0,   16'd0,      1'b0, 1'b0, 16'd0);
    add_probe(KIND_WRITE, 10'd639,  9'd479, 16'd1,      1'b0, 1'b0, 16'd0);
    add_probe(KIND_QUERY, 10'd639,  9'd479, 16'd0,      1'b0, 1'b0, 16'd0);
    add_probe(KIND_QUERY, 10'd645,  9'd485, 16'd0,      1'b0, 1'b0, 16'd0);
    add_probe(KIND_WRITE, 10'd640,  9'd0,   16'd7,      1'b0, 1'b0, 16'd0);
    add_probe(KIND_WRITE, 10'd1023, 9'd511, 16'hFFFF,   1'b0, 1'b0, 16'd0);
    add_probe(KIND_QUERY, 10'd1023, 9'd511, 16'd0,      1'b0, 1'b0, 16'd0);
    add_probe(KIND_WRITE, 10'd320,  9'd240, 16'd0,      1'b0, 1'b0, 16'd0);
    add_probe(KIND_QUERY, 10'd320,  9'd240, 16'd0,      1'b1, 1'b0, 16'd0);
    add_probe(KIND_WRITE, 10'd325,  9'd244, 16'h5555,   1'b0, 1'b0, 16'd0);
    add_probe(KIND_QUERY, 10'd320,  9'd240, 16'd0,      1'b0, 1'b0, 16'd0);
    add_probe(KIND_WRITE, 10'd316,  9'd236, 16'hAAAA,   1'b0, 1'b0, 16'd0);
    add_probe(KIND_QUERY, 10'd320,  9'd240, 16'd0,      1'b0, 1'b0, 16'd0);
    add_probe(KIND_QUERY, 10'd319,  9'd239, 16'd0,      1'b0, 1'b0, 16'd0);

    // Hold reset, then release on a falling edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_intrinsics(plan[0]);
    foreach (directed_rows[i]) begin
      p = directed_rows[i];
      want.found = p.found;
      want.px    = '0;
      want.py    = '0;
      want.pz    = p.z;
      want.hc    = p.col;
      want.hr    = p.row;
      push_item(p.kind, p.col, p.row, p.dval, p.typed, want);
    end

    for (int ph = 1; ph < PHASES; ph++) begin
      // Drain results and the write queue before touching the registers
      s_axis_tvalid <= 1'b0;
      while (points_due.size() != 0) @(negedge clk_i);
      repeat (DRAIN_CYCLES) @(negedge clk_i);
      set_intrinsics(plan[ph]);
      calm = (ph == 3);

      // Mostly clusters of writes around a pixel followed by its query
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = int'($urandom_range(99));
        if (pick < 70) begin
          cc = pick_col();
          cr = pick_row();
          nw = int'($urandom_range(5));
          repeat (nw) begin
            push_item(KIND_WRITE, COL_W'(cc + int'($urandom_range(20)) - 10),
                      ROW_W'(cr + int'($urandom_range(20)) - 10), pick_depth(), 1'b0, want);
          end
          push_item(KIND_QUERY, COL_W'(cc), ROW_W'(cr), DEPTH_W'($urandom), 1'b0, want);
          sent += nw + 1;
        end else if (pick < 85) begin
          push_item(KIND_WRITE, COL_W'($urandom_range(1023)), ROW_W'($urandom_range(511)),
                    pick_depth(), 1'b0, want);
          sent++;
        end else begin
          push_item(KIND_QUERY, COL_W'($urandom_range(1023)), ROW_W'($urandom_range(511)),
                    DEPTH_W'($urandom), 1'b0, want);
          sent++;
        end
      end
    end

    // Wait out the last results and watch for strays
    s_axis_tvalid <= 1'b0;
    calm = 1'b0;
    while (points_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && points_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
